// File: design/rpb_pkg.sv
`timescale 1ns / 1ps

package rpb_pkg;

    localparam logic [2:0] MODE_MULTIPLY  = 3'd0;
    localparam logic [2:0] MODE_SCREEN    = 3'd1;
    localparam logic [2:0] MODE_SUBTRACT  = 3'd2;
    localparam logic [2:0] MODE_OVERLAY   = 3'd3;
    localparam logic [2:0] MODE_ADD       = 3'd4;
    localparam logic [2:0] MODE_SCALE     = 3'd5;
    localparam logic [2:0] MODE_REPLICATE = 3'd6;
    localparam logic [2:0] MODE_PASS      = 3'd7;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_CHAN   = 2'd1;
    localparam logic [1:0] CFG_AMOUNT = 2'd2;

    localparam logic [1:0] CHAN_NONE = 2'd3;

    // floor(x / 255) == (x * DIV_K) >> DIV_SHIFT for x below 2^18
    localparam logic [18:0] DIV_K      = 19'd263173;
    localparam int          DIV_SHIFT  = 26;
    localparam logic [17:0] ROUND_BIAS = 18'd127;

    typedef struct packed {
        logic [7:0]        opa;
        logic [7:0]        opb;
        logic signed [8:0] amt;
        logic              dbl;
        logic              inv;
        logic              use_div;
        logic              scale;
        logic [7:0]        direct;
    } t_chan_op;

    function automatic logic [7:0] sat8(input logic signed [19:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 20'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

// File: design/rpb_front.sv
`timescale 1ns / 1ps

module rpb_front
    import rpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic [2:0][7:0]       i_top,
    input  logic [2:0][7:0]       i_bot,
    input  logic [2:0]            i_mode,
    input  logic [1:0]            i_chan,
    input  logic signed [8:0]     i_amount,
    output t_chan_op [2:0]        o_ops
);

    t_chan_op [2:0] n_ops;
    t_chan_op [2:0] r_ops;
    logic [7:0]     sel_val;
    logic           sel_ok;

    assign sel_ok  = (i_chan != CHAN_NONE);
    assign sel_val = sel_ok ? i_top[i_chan] : 8'd0;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ops[i].opa     = i_top[i];
            n_ops[i].opb     = i_bot[i];
            n_ops[i].amt     = i_amount;
            n_ops[i].dbl     = 1'b0;
            n_ops[i].inv     = 1'b0;
            n_ops[i].use_div = 1'b0;
            n_ops[i].scale   = 1'b0;
            n_ops[i].direct  = i_top[i];
            unique case (i_mode)
                MODE_MULTIPLY: begin
                    n_ops[i].use_div = 1'b1;
                end
                MODE_SCREEN: begin
                    n_ops[i].opa     = ~i_top[i];
                    n_ops[i].opb     = ~i_bot[i];
                    n_ops[i].inv     = 1'b1;
                    n_ops[i].use_div = 1'b1;
                end
                MODE_SUBTRACT: begin
                    n_ops[i].direct = (i_top[i] > i_bot[i]) ? (i_top[i] - i_bot[i]) : 8'd0;
                end
                MODE_OVERLAY: begin
                    n_ops[i].dbl     = 1'b1;
                    n_ops[i].use_div = 1'b1;
                    if (i_bot[i][7]) begin
                        n_ops[i].opa = ~i_top[i];
                        n_ops[i].opb = ~i_bot[i];
                        n_ops[i].inv = 1'b1;
                    end
                end
                MODE_ADD: begin
                    if (sel_ok && (i_chan == 2'(i))) begin
                        n_ops[i].direct = sat8(20'(signed'({2'b00, i_top[i]}))
                                               + 20'(i_amount));
                    end
                end
                MODE_SCALE: begin
                    if (sel_ok && (i_chan == 2'(i))) begin
                        n_ops[i].scale = 1'b1;
                    end
                end
                MODE_REPLICATE: begin
                    if (sel_ok) begin
                        n_ops[i].direct = sel_val;
                    end
                end
                MODE_PASS: begin
                    n_ops[i].direct = i_top[i];
                end
                default: begin
                    n_ops[i].direct = i_top[i];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ops <= n_ops;
    end

    assign o_ops = r_ops;

endmodule

// File: design/rpb_chan_core.sv
`timescale 1ns / 1ps

module rpb_chan_core
    import rpb_pkg::*;
(
    input  logic       i_clk,
    input  t_chan_op   i_op,
    output logic [7:0] o_res
);

    // stage 2: product
    logic signed [9:0]  mul_a;
    logic signed [9:0]  mul_b;
    logic signed [19:0] n_prod;
    logic signed [19:0] r_prod;
    logic               r_dbl2;
    logic               r_inv2;
    logic               r_div2;
    logic               r_scale2;
    logic [7:0]         r_direct2;

    assign mul_a  = signed'({2'b00, i_op.opa});
    assign mul_b  = i_op.scale ? signed'({i_op.amt[8], i_op.amt}) : signed'({2'b00, i_op.opb});
    assign n_prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod    <= n_prod;
        r_dbl2    <= i_op.dbl;
        r_inv2    <= i_op.inv;
        r_div2    <= i_op.use_div;
        r_scale2  <= i_op.scale;
        r_direct2 <= i_op.direct;
    end

    // stage 3: reciprocal multiply
    logic [17:0] div_x;
    logic [36:0] n_m;
    logic [36:0] r_m;
    logic [7:0]  n_direct3;
    logic [7:0]  r_direct3;
    logic        r_inv3;
    logic        r_div3;

    assign div_x = (r_dbl2 ? {r_prod[16:0], 1'b0} : {1'b0, r_prod[16:0]}) + ROUND_BIAS;
    assign n_m   = 37'(div_x) * 37'(DIV_K);
    assign n_direct3 = r_scale2 ? sat8(r_prod) : r_direct2;

    always_ff @(posedge i_clk) begin
        r_m       <= n_m;
        r_direct3 <= n_direct3;
        r_inv3    <= r_inv2;
        r_div3    <= r_div2;
    end

    // stage 4: pick result
    logic [7:0] quot;
    logic [7:0] n_res;
    logic [7:0] r_res;

    assign quot  = r_m[DIV_SHIFT+7:DIV_SHIFT];
    assign n_res = r_div3 ? (r_inv3 ? ~quot : quot) : r_direct3;

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// File: design/rgb_pixel_blend_unit.sv
`timescale 1ns / 1ps
// rgb pixel blend unit
// item in: pulse start with the six top/bottom channel values; busy is
// always low, so an item is taken on every cycle start is high.
// item out: o_strobe is high for one cycle with o_out_red/green/blue; the
// receiver must take it then, there is no backpressure.
// pipeline: operand select, 10x10 product, reciprocal multiply for the
// divide by 255 and result select, each a register stage.
// throughput: one item per cycle, set by the fully pipelined per-channel
// multipliers; items do not depend on each other.
// config: write i_cfg_data to register i_cfg_idx (0 mode, 1 channel,
// 2 signed amount) while i_cfg_we is high; index 3 is ignored. write only
// when no item is in flight.
// reset: i_rst_n low clears the config registers to zero (multiply mode) and
// drops all in-flight items; nothing is output until new items arrive.

module rgb_pixel_blend_unit
    import rpb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_top_red,
    input  logic [7:0] i_top_green,
    input  logic [7:0] i_top_blue,
    input  logic [7:0] i_bottom_red,
    input  logic [7:0] i_bottom_green,
    input  logic [7:0] i_bottom_blue,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    output logic       o_strobe,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue
);

    logic [2:0]        r_mode;
    logic [1:0]        r_chan;
    logic signed [8:0] r_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MULTIPLY;
            r_chan   <= 2'd0;
            r_amount <= 9'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                CFG_CHAN:   r_chan   <= i_cfg_data[1:0];
                CFG_AMOUNT: r_amount <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    logic [3:0] r_vld;
    logic [3:0] n_vld;

    assign n_vld = {r_vld[2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    logic [2:0][7:0] top_pix;
    logic [2:0][7:0] bot_pix;
    t_chan_op [2:0]  ops;
    logic [2:0][7:0] res;

    assign top_pix = {i_top_blue, i_top_green, i_top_red};
    assign bot_pix = {i_bottom_blue, i_bottom_green, i_bottom_red};

    rpb_front u_front (
        .i_clk    (i_clk),
        .i_top    (top_pix),
        .i_bot    (bot_pix),
        .i_mode   (r_mode),
        .i_chan   (r_chan),
        .i_amount (r_amount),
        .o_ops    (ops)
    );

    for (genvar g = 0; g < 3; g++) begin : g_chan
        rpb_chan_core u_core (
            .i_clk (i_clk),
            .i_op  (ops[g]),
            .o_res (res[g])
        );
    end

    assign o_strobe    = r_vld[3];
    assign o_out_red   = res[0];
    assign o_out_green = res[1];
    assign o_out_blue  = res[2];

endmodule
